### rtl/assert_macros.svh
// Assertion helpers used by the RTL datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/igdm_pkg.sv
package igdm_pkg;

    // Operation codes of a request
    localparam logic [1:0] OP_PLACE  = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [9:0] UNREACHED_RESET = 10'd99;
    localparam int         POP_LIMIT       = 1048576;
    localparam int         POPS_W          = 21;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CHECK,
        S_POP,
        S_SRD,
        S_SREAD,
        S_SEVAL,
        S_SLIVE,
        S_SLCHK,
        S_NADDR,
        S_NEVAL,
        S_NLIVE,
        S_NLCHK,
        S_NNEXT,
        S_SDONE,
        S_FINRD,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        ADDR_CELL,
        ADDR_CLR,
        ADDR_S,
        ADDR_N,
        ADDR_LIVE
    } addr_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_RESET,
        WR_PLACE,
        WR_REMOVE,
        WR_LOWER,
        WR_UNMARK
    } wr_kind_t;

    typedef struct packed {
        logic      load_req;
        logic      cap_coord;
        logic      clr_step;
        addr_sel_t addr_sel;
        wr_kind_t  wr_kind;
        logic      live_n;
        logic      q_push;
        logic      push_n;
        logic      q_pop;
        logic      q_flush;
        logic      cap_s;
        logic      cap_sdata;
        logic      cap_n;
        logic      k_clear;
        logic      k_inc;
        logic      res_emit;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       oor;
        logic [1:0] op;
        logic       q_empty;
        logic       pop_limit;
        logic       rd_mark;
        logic       rd_src_valid;
        logic       live_ok;
        logic       n_off;
        logic       k_last;
        logic       lower_better;
    } stat_t;

endpackage

### rtl/igdm_ctrl.sv
module igdm_ctrl
    import igdm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   raise_reg, raise_next;

    // Hold state and wave mode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            raise_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            raise_reg <= raise_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Clear the stores after reset, then sequence each request; places and removes run through the work queue
    always_comb
    begin
        state_next = state_reg;
        raise_next = raise_reg;
        cmd        = '0;
        cmd.addr_sel = ADDR_CELL;
        cmd.wr_kind  = WR_NONE;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.addr_sel = ADDR_CLR;
                cmd.wr_kind  = WR_RESET;
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.cap_coord = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (stat.oor)
                begin
                    cmd.res_emit = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (stat.op == OP_PLACE)
                begin
                    cmd.wr_kind = WR_PLACE;
                    cmd.q_push  = 1'b1;
                    state_next  = S_POP;
                end
                else if (stat.op == OP_REMOVE)
                begin
                    cmd.wr_kind = WR_REMOVE;
                    cmd.q_push  = 1'b1;
                    state_next  = S_POP;
                end
                else
                    state_next = S_FIN;
            end
            S_POP:
            begin
                if (stat.q_empty || stat.pop_limit)
                begin
                    cmd.q_flush = 1'b1;
                    state_next  = S_FINRD;
                end
                else
                begin
                    cmd.q_pop  = 1'b1;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                cmd.cap_s  = 1'b1;
                state_next = S_SREAD;
            end
            S_SREAD:
            begin
                cmd.addr_sel = ADDR_S;
                state_next   = S_SEVAL;
            end
            S_SEVAL:
            begin
                cmd.cap_sdata = 1'b1;
                cmd.k_clear   = 1'b1;
                if (stat.rd_mark)
                begin
                    raise_next = 1'b1;
                    state_next = S_NADDR;
                end
                else if (stat.rd_src_valid)
                    state_next = S_SLIVE;
                else
                    state_next = S_POP;
            end
            S_SLIVE:
            begin
                cmd.addr_sel = ADDR_LIVE;
                state_next   = S_SLCHK;
            end
            S_SLCHK:
            begin
                if (stat.live_ok)
                begin
                    raise_next = 1'b0;
                    state_next = S_NADDR;
                end
                else
                    state_next = S_POP;
            end
            S_NADDR:
            begin
                if (stat.n_off)
                begin
                    if (stat.k_last)
                        state_next = S_SDONE;
                    else
                        cmd.k_inc = 1'b1;
                end
                else
                begin
                    cmd.addr_sel = ADDR_N;
                    state_next   = S_NEVAL;
                end
            end
            S_NEVAL:
            begin
                cmd.cap_n  = 1'b1;
                state_next = S_NNEXT;
                if (raise_reg)
                begin
                    if (stat.rd_src_valid && !stat.rd_mark)
                        state_next = S_NLIVE;
                end
                else if (!stat.rd_mark && stat.lower_better)
                begin
                    cmd.addr_sel = ADDR_N;
                    cmd.wr_kind  = WR_LOWER;
                    cmd.q_push   = 1'b1;
                    cmd.push_n   = 1'b1;
                end
            end
            S_NLIVE:
            begin
                cmd.addr_sel = ADDR_LIVE;
                cmd.live_n   = 1'b1;
                state_next   = S_NLCHK;
            end
            S_NLCHK:
            begin
                cmd.live_n   = 1'b1;
                cmd.addr_sel = ADDR_N;
                cmd.q_push   = 1'b1;
                cmd.push_n   = 1'b1;
                if (!stat.live_ok)
                    cmd.wr_kind = WR_REMOVE;
                state_next = S_NNEXT;
            end
            S_NNEXT:
            begin
                if (stat.k_last)
                    state_next = S_SDONE;
                else
                begin
                    cmd.k_inc  = 1'b1;
                    state_next = S_NADDR;
                end
            end
            S_SDONE:
            begin
                cmd.addr_sel = ADDR_S;
                if (raise_reg)
                    cmd.wr_kind = WR_UNMARK;
                state_next = S_POP;
            end
            S_FINRD:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.res_emit = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/igdm_datapath.sv
`include "assert_macros.svh"

module igdm_datapath
    import igdm_pkg::*;
#(
    parameter int GRID_SIDE   = 16,
    parameter int LAYER_COUNT = 5,
    parameter int QUEUE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       stat,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    input  logic [1:0]  operation,
    input  logic [7:0]  cell_req,
    input  logic [2:0]  layer,
    output logic        done,
    output logic [9:0]  distance,
    output logic [7:0]  nearest_cell,
    output logic        nearest_valid,
    output logic [15:0] pops_done,
    output logic        queue_overflow
);

    localparam int CW      = $clog2(GRID_SIDE);
    localparam int CELLS   = GRID_SIDE * GRID_SIDE;
    localparam int ENTRIES = CELLS * LAYER_COUNT;
    localparam int AW      = $clog2(ENTRIES);
    localparam int SW      = 2 * CW + 1;
    localparam int QW      = 2 * CW;
    localparam int QAW     = $clog2(QUEUE_DEPTH);
    localparam int QCW     = $clog2(QUEUE_DEPTH + 1);
    localparam int DIV_SH  = 17;
    localparam int DIV_M   = ((1 << DIV_SH) + GRID_SIDE - 1) / GRID_SIDE;

    localparam logic [CW-1:0] EDGE_HI = CW'(GRID_SIDE - 1);

    // Split a cell index into row and column by reciprocal multiplication
    function automatic logic [15:0] div_cell(input logic [7:0] c);
        logic [24:0] prod;
        logic [7:0]  q;
        logic [7:0]  r;
        prod = 25'(c) * 25'(DIV_M);
        q    = 8'(prod >> DIV_SH);
        r    = 8'(32'(c) - 32'(q) * GRID_SIDE);
        return {q, r};
    endfunction

    logic [9:0]    unreach_reg;
    logic [1:0]    op_reg;
    logic [7:0]    cell_reg;
    logic [2:0]    layer_reg;
    logic [CW-1:0] cx_reg, cy_reg;
    logic [AW-1:0] base_reg;
    logic [AW-1:0] clr_reg;
    logic [QW-1:0] s_reg;
    logic [SW-1:0] src_s_reg;
    logic [SW-1:0] src_n_reg;
    logic [1:0]    k_reg;
    logic [POPS_W-1:0] pops_reg;
    logic          ovf_reg;

    // Hold the unreached distance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            unreach_reg <= UNREACHED_RESET;
        else if (cfg_we)
            unreach_reg <= cfg_wdata;
    end

    // Latch the request and its decoded coordinates
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg    <= operation;
            cell_reg  <= cell_req;
            layer_reg <= layer;
        end
        if (cmd.cap_coord)
        begin
            cy_reg   <= CW'(div_cell(cell_reg) >> 8);
            cx_reg   <= CW'(div_cell(cell_reg) & 16'h00FF);
            base_reg <= AW'(32'(layer_reg) * CELLS);
        end
    end

    logic oor;
    assign oor = (32'(cell_reg) >= CELLS) || (32'(layer_reg) >= LAYER_COUNT);

    // Map a row and column of the current layer to a store address
    function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] y, input logic [CW-1:0] x,
                                              input logic [AW-1:0] base);
        return AW'(32'(base) + 32'(y) * GRID_SIDE + 32'(x));
    endfunction

    // Neighbor of the popped cell in the current direction
    logic [CW-1:0] sx, sy, nx, ny;
    logic          n_off;
    assign sx = s_reg[CW-1:0];
    assign sy = s_reg[QW-1:CW];

    always_comb
    begin
        nx    = sx;
        ny    = sy;
        n_off = 1'b0;
        case (k_reg)
            2'd0:
            begin
                n_off = (sx == '0);
                nx    = sx - 1'b1;
            end
            2'd1:
            begin
                n_off = (sx == EDGE_HI);
                nx    = sx + 1'b1;
            end
            2'd2:
            begin
                n_off = (sy == '0);
                ny    = sy - 1'b1;
            end
            default:
            begin
                n_off = (sy == EDGE_HI);
                ny    = sy + 1'b1;
            end
        endcase
    end

    // Store read ports
    logic [9:0]    rd_dist_reg;
    logic [SW-1:0] rd_src_reg;
    logic          rd_mark_reg;

    // Manhattan distance from the popped cell's source to the neighbor
    logic [CW-1:0] ex, ey;
    logic [9:0]    dx, dy, dman;
    assign ex   = src_s_reg[CW-1:0];
    assign ey   = src_s_reg[2*CW-1:CW];
    assign dx   = (ex > nx) ? 10'(ex - nx) : 10'(nx - ex);
    assign dy   = (ey > ny) ? 10'(ey - ny) : 10'(ny - ey);
    assign dman = dx + dy;

    // Select the store address
    logic [SW-1:0] live_src;
    logic [AW-1:0] addr;
    assign live_src = cmd.live_n ? src_n_reg : src_s_reg;

    always_comb
    begin
        unique case (cmd.addr_sel)
            ADDR_CLR:  addr = clr_reg;
            ADDR_S:    addr = slot_of(sy, sx, base_reg);
            ADDR_N:    addr = slot_of(ny, nx, base_reg);
            ADDR_LIVE: addr = slot_of(live_src[2*CW-1:CW], live_src[CW-1:0], base_reg);
            default:   addr = slot_of(cy_reg, cx_reg, base_reg);
        endcase
    end

    // Decode the write kind into store enables and data
    logic          we_dist, we_src, we_mark;
    logic [9:0]    wdist;
    logic [SW-1:0] wsrc;
    logic          wmark;

    always_comb
    begin
        we_dist = 1'b0;
        we_src  = 1'b0;
        we_mark = 1'b0;
        wdist   = unreach_reg;
        wsrc    = '0;
        wmark   = 1'b0;
        unique case (cmd.wr_kind)
            WR_RESET:
            begin
                {we_dist, we_src, we_mark} = 3'b111;
                wdist = UNREACHED_RESET;
            end
            WR_PLACE:
            begin
                {we_dist, we_src} = 2'b11;
                wdist = '0;
                wsrc  = {1'b1, cy_reg, cx_reg};
            end
            WR_REMOVE:
            begin
                {we_dist, we_src, we_mark} = 3'b111;
                wmark = 1'b1;
            end
            WR_LOWER:
            begin
                {we_dist, we_src} = 2'b11;
                wdist = dman;
                wsrc  = src_s_reg;
            end
            WR_UNMARK:
            begin
                we_mark = 1'b1;
            end
            default:
            begin
                we_dist = 1'b0;
            end
        endcase
    end

    // Distance, source and raise-mark stores
    logic [9:0]    dist_mem [ENTRIES];
    logic [SW-1:0] src_mem  [ENTRIES];
    logic          mark_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we_dist)
            dist_mem[addr] <= wdist;
        if (we_src)
            src_mem[addr] <= wsrc;
        if (we_mark)
            mark_mem[addr] <= wmark;
        rd_dist_reg <= dist_mem[addr];
        rd_src_reg  <= src_mem[addr];
        rd_mark_reg <= mark_mem[addr];
    end

    // Work queue
    logic [QW-1:0]  q_mem [QUEUE_DEPTH];
    logic [QW-1:0]  q_rd_reg;
    logic [QAW-1:0] head_reg, tail_reg;
    logic [QCW-1:0] count_reg;
    logic           q_full, q_write;
    logic [QW-1:0]  q_wdata;

    assign q_full  = (32'(count_reg) == QUEUE_DEPTH);
    assign q_write = cmd.q_push && !q_full;
    assign q_wdata = cmd.push_n ? {ny, nx} : {cy_reg, cx_reg};

    always_ff @(posedge clk)
    begin
        if (q_write)
            q_mem[tail_reg] <= q_wdata;
        q_rd_reg <= q_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.q_flush)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (q_write)
                tail_reg <= (32'(tail_reg) == QUEUE_DEPTH - 1) ? '0 : tail_reg + 1'b1;
            if (cmd.q_pop)
                head_reg <= (32'(head_reg) == QUEUE_DEPTH - 1) ? '0 : head_reg + 1'b1;
            count_reg <= count_reg + QCW'(q_write) - QCW'(cmd.q_pop);
        end
    end

    // Advance clear sweep, direction, pop count and overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            k_reg    <= '0;
            pops_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.k_clear)
                k_reg <= '0;
            else if (cmd.k_inc)
                k_reg <= k_reg + 1'b1;
            if (cmd.load_req)
            begin
                pops_reg <= '0;
                ovf_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.q_pop)
                    pops_reg <= pops_reg + 1'b1;
                if (cmd.q_push && q_full)
                    ovf_reg <= 1'b1;
            end
        end
    end

    // Capture the popped cell and its entries
    always_ff @(posedge clk)
    begin
        if (cmd.cap_s)
            s_reg <= q_rd_reg;
        if (cmd.cap_sdata)
            src_s_reg <= rd_src_reg;
        if (cmd.cap_n)
            src_n_reg <= rd_src_reg;
    end

    // Status to the controller
    always_comb
    begin
        stat.clr_last     = (32'(clr_reg) == ENTRIES - 1);
        stat.oor          = oor;
        stat.op           = op_reg;
        stat.q_empty      = (count_reg == '0);
        stat.pop_limit    = (32'(pops_reg) == POP_LIMIT);
        stat.rd_mark      = rd_mark_reg;
        stat.rd_src_valid = rd_src_reg[SW-1];
        stat.live_ok      = live_src[SW-1] && (rd_src_reg == live_src);
        stat.n_off        = n_off;
        stat.k_last       = (k_reg == 2'd3);
        stat.lower_better = (dman < rd_dist_reg);
    end

    // Pulse done for one cycle with each result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= cmd.res_emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_emit)
        begin
            if (oor)
            begin
                distance       <= unreach_reg;
                nearest_cell   <= '0;
                nearest_valid  <= 1'b0;
                pops_done      <= '0;
                queue_overflow <= 1'b0;
            end
            else
            begin
                distance      <= rd_dist_reg;
                nearest_valid <= rd_src_reg[SW-1];
                nearest_cell  <= rd_src_reg[SW-1]
                    ? 8'(32'(rd_src_reg[2*CW-1:CW]) * GRID_SIDE + 32'(rd_src_reg[CW-1:0]))
                    : 8'd0;
                pops_done      <= (pops_reg > POPS_W'(16'hFFFF)) ? 16'hFFFF : pops_reg[15:0];
                queue_overflow <= ovf_reg;
            end
        end
    end

    `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, 32'(count_reg) <= QUEUE_DEPTH)
    `ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd.q_pop, count_reg != '0)
    `ASSERT_NXT(a_emit_done, clk, rst_n, cmd.res_emit, done)
    `ASSERT_NXT(a_flush_empty, clk, rst_n, cmd.q_flush, count_reg == '0)

endmodule

### rtl/incremental_grid_distance_map_top.sv
// Incremental grid distance map. After reset a clearing pass over the
// GRID_SIDE*GRID_SIDE*LAYER_COUNT store entries (1280 at the defaults) sets
// every cell to the reset distance; busy stays high meanwhile. A request is
// taken when start is high and busy low. A read answers after the decode,
// check and final states. A place or remove answers after the wavefront
// drain, in which each queue pop reads the single-port stores once per
// neighbor plus once per source liveness check. Each result is shown for
// exactly one cycle with done high and cannot be held off.
module incremental_grid_distance_map_top
    import igdm_pkg::*;
#(
    parameter int GRID_SIDE   = 16,
    parameter int LAYER_COUNT = 5,
    parameter int QUEUE_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [7:0]  cell_req,
    input  logic [2:0]  layer,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,
    output logic        done,
    output logic [9:0]  distance,
    output logic [7:0]  nearest_cell,
    output logic        nearest_valid,
    output logic [15:0] pops_done,
    output logic        queue_overflow
);

    cmd_t  cmd;
    stat_t stat;

    igdm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    igdm_datapath #(
        .GRID_SIDE   (GRID_SIDE),
        .LAYER_COUNT (LAYER_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .operation      (operation),
        .cell_req       (cell_req),
        .layer          (layer),
        .done           (done),
        .distance       (distance),
        .nearest_cell   (nearest_cell),
        .nearest_valid  (nearest_valid),
        .pops_done      (pops_done),
        .queue_overflow (queue_overflow)
    );

endmodule

### tb/tb.sv
module tb
    import igdm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIDE        = 16;
    localparam int LAYERS      = 5;
    localparam int CELLS       = SIDE * SIDE;
    localparam int QDEPTH      = 1024;
    localparam int ANS_DEPTH   = 16;
    localparam int DRAIN_LIMIT = 1048576;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam longint CYCLE_LIMIT = 200_000_000;

    typedef struct {
        logic [9:0]  distance;
        logic [7:0]  nearest_cell;
        logic        nearest_valid;
        logic [15:0] pops_done;
        logic        queue_overflow;
    } answer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  operation = OP_READ;
    logic [7:0]  cell_req = '0;
    logic [2:0]  layer = '0;
    logic        cfg_we = 1'b0;
    logic [9:0]  cfg_wdata = '0;
    logic        done;
    logic [9:0]  distance;
    logic [7:0]  nearest_cell;
    logic        nearest_valid;
    logic [15:0] pops_done;
    logic        queue_overflow;

    // mirror of the distance map
    logic [9:0]  unreached_m;
    logic [9:0]  dist_m [CELLS*LAYERS];
    int unsigned src_m  [CELLS*LAYERS];
    bit          mark_m [CELLS*LAYERS];
    int unsigned wave_mem [QDEPTH];
    int unsigned wave_head = 0;
    int unsigned wave_count = 0;
    bit          wave_over;
    int unsigned cur_lay;

    // ring of predicted answers
    answer_t     ans_mem [ANS_DEPTH];
    int          ans_wr = 0;
    int          ans_rd = 0;
    int          failures = 0;
    longint      cycles = 0;
    bit          idle_enable = 1'b1;

    incremental_grid_distance_map_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .cell_req(cell_req), .layer(layer),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
        .distance(distance), .nearest_cell(nearest_cell),
        .nearest_valid(nearest_valid), .pops_done(pops_done),
        .queue_overflow(queue_overflow)
    );

    always #6 clk = ~clk;

    // abort on runaway
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int unsigned idx(int unsigned c);
        return c * LAYERS + cur_lay;
    endfunction

    function automatic bit source_live(int unsigned e);
        if (e == 0 || e > CELLS)
            return 1'b0;
        return src_m[idx(e - 1)] == e;
    endfunction

    function automatic int unsigned step_to(int unsigned c, int k);
        int x;
        int y;
        x = int'(c % SIDE);
        y = int'(c / SIDE);
        case (k)
            0: x = x - 1;
            1: x = x + 1;
            2: y = y - 1;
            default: y = y + 1;
        endcase
        if (x < 0 || x >= SIDE || y < 0 || y >= SIDE)
            return CELLS;
        return y * SIDE + x;
    endfunction

    function automatic int unsigned grid_gap(int unsigned a, int unsigned b);
        int dx;
        int dy;
        dx = int'(a % SIDE) - int'(b % SIDE);
        dy = int'(a / SIDE) - int'(b / SIDE);
        return (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
    endfunction

    function automatic void enqueue_cell(int unsigned c);
        if (wave_count >= QDEPTH)
            wave_over = 1'b1;
        else
        begin
            wave_mem[(wave_head + wave_count) % QDEPTH] = c;
            wave_count++;
        end
    endfunction

    function automatic int unsigned take_wave_cell();
        int unsigned c;
        c = wave_mem[wave_head];
        wave_head = (wave_head + 1) % QDEPTH;
        wave_count--;
        return c;
    endfunction

    function automatic void wipe_cell(int unsigned c);
        dist_m[idx(c)] = unreached_m;
        src_m[idx(c)] = 0;
    endfunction

    // run the raise and lower wavefronts until the work queue empties or the pop limit is hit
    function automatic int unsigned run_waves();
        int unsigned pops;
        int unsigned s;
        int unsigned n;
        int unsigned e;
        int unsigned d;
        pops = 0;
        while (wave_count != 0 && pops < DRAIN_LIMIT)
        begin
            s = take_wave_cell();
            if (mark_m[idx(s)])
            begin
                for (int k = 0; k < 4; k++)
                begin
                    n = step_to(s, k);
                    if (n < CELLS && src_m[idx(n)] != 0 && !mark_m[idx(n)])
                    begin
                        if (!source_live(src_m[idx(n)]))
                        begin
                            wipe_cell(n);
                            mark_m[idx(n)] = 1'b1;
                        end
                        enqueue_cell(n);
                    end
                end
                mark_m[idx(s)] = 1'b0;
            end
            else if (source_live(src_m[idx(s)]))
            begin
                e = src_m[idx(s)];
                for (int k = 0; k < 4; k++)
                begin
                    n = step_to(s, k);
                    if (n < CELLS && !mark_m[idx(n)])
                    begin
                        d = grid_gap(e - 1, n);
                        if (d < dist_m[idx(n)])
                        begin
                            dist_m[idx(n)] = d[9:0];
                            src_m[idx(n)] = e;
                            enqueue_cell(n);
                        end
                    end
                end
            end
            pops++;
        end
        wave_count = 0;
        wave_head = 0;
        return pops > 65535 ? 65535 : pops;
    endfunction

    function automatic answer_t apply_request(logic [1:0] op, logic [7:0] c, logic [2:0] lay);
        answer_t     r;
        int unsigned pops;
        int unsigned e;
        pops = 0;
        wave_over = 1'b0;
        if (lay >= LAYERS)
        begin
            r.distance = unreached_m;
            r.nearest_cell = '0;
            r.nearest_valid = 1'b0;
            r.pops_done = '0;
            r.queue_overflow = 1'b0;
            return r;
        end
        cur_lay = lay;
        if (op == OP_PLACE)
        begin
            src_m[idx(c)] = c + 1;
            dist_m[idx(c)] = '0;
            enqueue_cell(c);
            pops = run_waves();
        end
        else if (op == OP_REMOVE)
        begin
            wipe_cell(c);
            mark_m[idx(c)] = 1'b1;
            enqueue_cell(c);
            pops = run_waves();
        end
        e = src_m[idx(c)];
        r.distance = dist_m[idx(c)];
        r.nearest_cell = e != 0 ? 8'(e - 1) : 8'd0;
        r.nearest_valid = e != 0;
        r.pops_done = 16'(pops);
        r.queue_overflow = wave_over;
        return r;
    endfunction

    // send one request and hold it until the block takes it
    task automatic send_request(logic [1:0] op, logic [7:0] c, logic [2:0] lay);
        bit taken;
        while (idle_enable && $urandom_range(99) < 14)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        cell_req <= c;
        layer <= lay;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
        ans_mem[ans_wr % ANS_DEPTH] = apply_request(op, c, lay);
        ans_wr++;
    endtask

    // drop start and wait for every outstanding answer
    task automatic drain_answers();
        start <= 1'b0;
        while (ans_wr != ans_rd)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_unreached(logic [9:0] v);
        drain_answers();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        unreached_m = v;
    endtask

    // check each answer against the oldest prediction
    always @(posedge clk)
    begin
        answer_t x;
        if (rst_n && done)
        begin
            if (ans_wr == ans_rd)
            begin
                $error("answer with no request outstanding");
                failures++;
            end
            else
            begin
                x = ans_mem[ans_rd % ANS_DEPTH];
                ans_rd++;
                if (distance !== x.distance)
                begin
                    $error("distance exp %0d got %0d", x.distance, distance);
                    failures++;
                end
                if (nearest_cell !== x.nearest_cell)
                begin
                    $error("nearest_cell exp %0d got %0d", x.nearest_cell, nearest_cell);
                    failures++;
                end
                if (nearest_valid !== x.nearest_valid)
                begin
                    $error("nearest_valid exp %0d got %0d", x.nearest_valid, nearest_valid);
                    failures++;
                end
                if (pops_done !== x.pops_done)
                begin
                    $error("pops_done exp %0d got %0d", x.pops_done, pops_done);
                    failures++;
                end
                if (queue_overflow !== x.queue_overflow)
                begin
                    $error("queue_overflow exp %0d got %0d", x.queue_overflow, queue_overflow);
                    failures++;
                end
            end
        end
    end

    task automatic test_directed();
        send_request(OP_READ, 8'd0, 3'd0);
        send_request(OP_PLACE, 8'd0, 3'd0);
        send_request(OP_PLACE, 8'd255, 3'd0);
        send_request(OP_READ, 8'd136, 3'd0);
        send_request(OP_SPARE, 8'd17, 3'd0);
        send_request(OP_PLACE, 8'd255, 3'd4);
        send_request(OP_READ, 8'd0, 3'd4);
        send_request(OP_PLACE, 8'd7, 3'd5);
        send_request(OP_REMOVE, 8'd0, 3'd7);
        send_request(OP_READ, 8'd255, 3'd6);
        send_request(OP_REMOVE, 8'd0, 3'd0);
        send_request(OP_READ, 8'd1, 3'd0);
        send_request(OP_REMOVE, 8'd255, 3'd0);
        send_request(OP_READ, 8'd128, 3'd0);
        send_request(OP_REMOVE, 8'd100, 3'd2);
        send_request(OP_PLACE, 8'd100, 3'd2);
        send_request(OP_PLACE, 8'd100, 3'd2);
        send_request(OP_REMOVE, 8'd100, 3'd2);
    endtask

    task automatic test_unreached_extremes();
        write_unreached(10'd0);
        send_request(OP_PLACE, 8'd34, 3'd1);
        send_request(OP_READ, 8'd35, 3'd1);
        send_request(OP_REMOVE, 8'd34, 3'd1);
        write_unreached(10'd1023);
        send_request(OP_PLACE, 8'd34, 3'd1);
        send_request(OP_READ, 8'd200, 3'd1);
        send_request(OP_READ, 8'd3, 3'd6);
        send_request(OP_REMOVE, 8'd34, 3'd1);
    endtask

    task automatic test_random(int count);
        logic [1:0] op;
        logic [2:0] lay;
        int         pick;
        for (int i = 0; i < count; i++)
        begin
            idle_enable = !(i >= count / 3 && i < count / 2);
            pick = $urandom_range(99);
            op = pick < 35 ? OP_READ : (pick < 68 ? OP_PLACE : (pick < 97 ? OP_REMOVE : OP_SPARE));
            lay = $urandom_range(99) < 94 ? 3'($urandom_range(LAYERS - 1)) : 3'($urandom_range(7));
            send_request(op, 8'($urandom), lay);
            if (i % 400 == 399)
                write_unreached(10'($urandom_range(1023)));
        end
        idle_enable = 1'b1;
    endtask

    initial
    begin
        unreached_m = UNREACHED_RESET;
        foreach (dist_m[i])
        begin
            dist_m[i] = UNREACHED_RESET;
            src_m[i] = 0;
            mark_m[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_unreached_extremes();
        write_unreached(UNREACHED_RESET);
        test_random(1500);
        drain_answers();
        repeat (50) @(posedge clk);
        if (failures == 0 && ans_wr == ans_rd)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/igdm_pkg.sv
rtl/igdm_ctrl.sv
rtl/igdm_datapath.sv
rtl/incremental_grid_distance_map_top.sv
tb/tb.sv
